/* sv/jdh_pkg.sv */
// ----------------------------------------------------------------------------
// jdh_pkg
// Shared types, widths and codes of the joystick direction hysteresis block.
// ----------------------------------------------------------------------------
`default_nettype none

package jdh_pkg;

   // ADC sample and register width
   localparam int unsigned DATA_W       = 12;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned DIR_W        = 3;
   localparam int unsigned SAMPLES_DEF  = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_RADIUS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXIT_RADIUS  = 2'd3;

   // Register reset values
   localparam logic [DATA_W-1:0] CENTER_RST = 12'd2048;
   localparam logic [DATA_W-1:0] ENTER_RST  = 12'd1200;
   localparam logic [DATA_W-1:0] EXIT_RST   = 12'd900;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] sample_x;
      logic [DATA_W-1:0] sample_y;
      logic              sample_valid;
   } req_type;

   typedef struct packed {
      logic [DIR_W-1:0] direction;
      logic             moved;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/jdh_div.sv */
// ----------------------------------------------------------------------------
// jdh_div
// Iterative restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jdh_div
   import jdh_pkg::*;
#(
   parameter int unsigned SUM_W = 14,
   parameter int unsigned CNT_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient
);

   localparam int unsigned STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // Shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, dq_ff[SUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dq_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // Subtract when the divisor fits, shift the quotient bit in
         rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
         dq_in   = {dq_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff[DATA_W-1:0];

endmodule

`default_nettype wire

/* sv/joystick_direction_hysteresis.sv */
// ----------------------------------------------------------------------------
// joystick_direction_hysteresis
// Windowed joystick averaging with a squared-radius deadzone and hysteresis.
// ----------------------------------------------------------------------------
// Each X/Y sample item is taken while the block is idle and summed when its
// valid flag is set; every SAMPLES-th item closes the window and yields one
// result item. After the closing item of a window with at least one valid
// sample, req_stall stays high while the iterative divider forms the X and Y
// averages one quotient bit per cycle (SUM_W = 12 + clog2(SAMPLES) quotient
// bits each), then one shared multiplier squares dx, dy and both radii in
// turn before the hysteresis decision and the output state. After the
// closing item of an empty window req_stall stays high in the output state
// only. No sample item is taken while a window is being evaluated; samples
// keep flowing while a finished result waits on rsp_stall, and a window end
// waits in the output state for it to drain, with req_stall held high.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_direction_hysteresis
   import jdh_pkg::*;
#(
   parameter int unsigned SAMPLES = SAMPLES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(SAMPLES + 1);
   localparam int unsigned SUM_W  = DATA_W + $clog2(SAMPLES);
   localparam int unsigned DIFF_W = DATA_W + 1;
   localparam int unsigned PROD_W = 2 * DIFF_W;
   localparam int unsigned DIST_W = PROD_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIVX, ST_DIVY, ST_SQX, ST_SQY, ST_SQEN, ST_SQEX,
      ST_DECIDE, ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [DATA_W-1:0]   center_x_ff, center_y_ff, enter_ff, exit_ff;
   logic [SUM_W-1:0]    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [CNT_W-1:0]    count_ff, count_in, index_ff, index_in;
   logic                moved_ff, moved_in;
   logic [DIR_W-1:0]    held_ff, held_in;
   logic                start_ff, start_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [PROD_W-1:0]   enter_sq_ff, enter_sq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                div_done;
   logic [DATA_W-1:0]   quotient;
   logic [SUM_W-1:0]    dividend;
   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [DIFF_W-1:0]   abs_x, abs_y;
   logic [DIR_W-1:0]    pick;
   logic                out_free;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Divider on the window sums
   assign dividend = (state_ff == ST_DIVX) ? sum_x_ff : sum_y_ff;

   jdh_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Shared multiplier: squares dx, dy, enter and exit radius in turn
   always_comb begin
      case (state_ff)
         ST_SQX: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         ST_SQY: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         ST_SQEN: begin
            mul_a = $signed({1'b0, enter_ff});
            mul_b = $signed({1'b0, enter_ff});
         end
         default: begin
            mul_a = $signed({1'b0, exit_ff});
            mul_b = $signed({1'b0, exit_ff});
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Dominant axis, ties go to horizontal
   assign abs_x = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign abs_y = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);
   always_comb begin
      if (abs_x >= abs_y) begin
         pick = dx_ff[DIFF_W-1] ? DIR_LEFT : DIR_RIGHT;
      end else begin
         pick = (!dy_ff[DIFF_W-1] && (dy_ff != '0)) ? DIR_UP : DIR_DOWN;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      moved_in     = moved_ff;
      held_in      = held_ff;
      start_in     = 1'b0;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      dist_in      = dist_ff;
      enter_sq_in  = enter_sq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Accumulate the item and close the window on the last one
               if (req_data.sample_valid) begin
                  sum_x_in = sum_x_ff + SUM_W'(req_data.sample_x);
                  sum_y_in = sum_y_ff + SUM_W'(req_data.sample_y);
                  count_in = count_ff + 1'b1;
               end
               index_in = index_ff + 1'b1;
               if (index_ff == CNT_W'(SAMPLES - 1)) begin
                  index_in = '0;
                  if (req_data.sample_valid || (count_ff != '0)) begin
                     state_in = ST_DIVX;
                     start_in = 1'b1;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_DIVX: begin
            if (div_done) begin
               dx_in    = $signed({1'b0, quotient}) - $signed({1'b0, center_x_ff});
               start_in = 1'b1;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               dy_in    = $signed({1'b0, quotient}) - $signed({1'b0, center_y_ff});
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            dist_in  = DIST_W'(prod_ff);
            prod_in  = PROD_W'(mul_p);
            state_in = ST_SQEN;
         end
         ST_SQEN: begin
            dist_in  = dist_ff + DIST_W'(prod_ff);
            prod_in  = PROD_W'(mul_p);
            state_in = ST_SQEX;
         end
         ST_SQEX: begin
            enter_sq_in = prod_ff;
            prod_in     = PROD_W'(mul_p);
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Hysteresis: enter at or beyond enter radius, leave at or within exit
            if (!moved_ff) begin
               if (dist_ff >= DIST_W'(enter_sq_ff)) begin
                  moved_in = 1'b1;
                  held_in  = pick;
               end else begin
                  held_in  = DIR_NONE;
               end
            end else begin
               if (dist_ff <= DIST_W'(prod_ff)) begin
                  moved_in = 1'b0;
                  held_in  = DIR_NONE;
               end else begin
                  held_in  = pick;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold until the result register is free, then clear the window
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.direction = moved_ff ? held_ff : DIR_NONE;
               rsp_data_in.moved     = moved_ff;
               sum_x_in              = '0;
               sum_y_in              = '0;
               count_in              = '0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         count_ff     <= '0;
         index_ff     <= '0;
         moved_ff     <= 1'b0;
         held_ff      <= DIR_NONE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         moved_ff     <= moved_in;
         held_ff      <= held_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      dist_ff     <= dist_in;
      enter_sq_ff <= enter_sq_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_RST;
         center_y_ff <= CENTER_RST;
         enter_ff    <= ENTER_RST;
         exit_ff     <= EXIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:     center_x_ff <= csr_wdata;
            CSR_CENTER_Y:     center_y_ff <= csr_wdata;
            CSR_ENTER_RADIUS: enter_ff    <= csr_wdata;
            CSR_EXIT_RADIUS:  exit_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
